// ===== src/lstm_pkg.sv =====
// Shared types and constants for the latency statistics table.
// Holds the entry layout, command codes and controller states.
// No dependencies.
package lstm_pkg;

  localparam int unsigned SlotW     = 3;
  localparam int unsigned ProbeW    = 6;
  localparam int unsigned SampleW   = 32;
  localparam int unsigned CountW    = 32;
  localparam int unsigned TotalW    = 48;
  localparam int unsigned DropW     = SampleW + 2;
  localparam int unsigned TrimCount = 4;

  localparam int unsigned ThreadSlotsDef   = 8;
  localparam int unsigned ProbesPerSlotDef = 64;

  typedef enum logic [1:0] {
    CMD_RECORD = 2'd0,
    CMD_REPORT = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_REPORT,
    ST_TRIM,
    ST_DIVIDE,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic               valid;
    logic [CountW-1:0]  calls;
    logic [TotalW-1:0]  total;
    logic [SampleW-1:0] max_first;
    logic [SampleW-1:0] max_second;
    logic [SampleW-1:0] min_first;
    logic [SampleW-1:0] min_second;
  } entry_t;

endpackage

// ===== src/lstm_mem.sv =====
// Statistics entry memory: one write port, one read port, registered read data.
// Depends on lstm_pkg for the entry layout.
module lstm_mem #(
  parameter int unsigned Depth = 512,
  parameter int unsigned AddrW = 9
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  lstm_pkg::entry_t     wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output lstm_pkg::entry_t     rdata_o
);

  lstm_pkg::entry_t mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== src/lstm_div.sv =====
// Restoring divider, one quotient bit per cycle, for the trimmed average.
// Depends on lstm_pkg for the total and count widths.
module lstm_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [lstm_pkg::TotalW-1:0]    dividend_i,
  input  logic [lstm_pkg::CountW-1:0]    divisor_i,
  output logic                           done_o,
  output logic [lstm_pkg::TotalW-1:0]    quotient_o
);

  localparam int unsigned QW   = lstm_pkg::TotalW;
  localparam int unsigned DW   = lstm_pkg::CountW;
  localparam int unsigned CntW = $clog2(QW + 1);

  logic            run_q, run_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [QW-1:0]   quo_q, quo_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   dvs_q, dvs_d;
  logic [DW:0]     shifted;
  logic            ge;

  assign shifted = {rem_q, quo_q[QW-1]};
  assign ge      = shifted >= {1'b0, dvs_q};

  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CntW'(QW);
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (run_q) begin
      if (cnt_q != '0) begin
        cnt_d = cnt_q - 1'b1;
        quo_d = {quo_q[QW-2:0], ge};
        rem_d = ge ? DW'(shifted - {1'b0, dvs_q}) : shifted[DW-1:0];
      end else begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = run_q && (cnt_q == '0);
  assign quotient_o = quo_q;

endmodule

// ===== src/latency_stats_trimmed_mean.sv =====
// Top level of the latency statistics table with trimmed-mean reports.
// Depends on lstm_pkg, lstm_mem and lstm_div.
//
// One item at a time: for records, reports and clears, busy is high from the
// cycle after acceptance until the item is finished. A record reads the entry
// at acceptance and writes it back updated in the update state, a read-modify-
// write on the memory port. A report on an entry out of range, not valid or with
// four or fewer calls goes straight to the result state; a full report passes
// the trim and divide states, where the 48-step bit-serial divider forms the
// average. A clear item sweeps the memory one entry a cycle over all
// THREAD_SLOTS * PROBES_PER_SLOT entries; after reset the same sweep runs first.
// A report result shows for exactly one cycle with done_o high and cannot be
// held off by the receiver; records, clears and command code three give none.
module latency_stats_trimmed_mean #(
  parameter int unsigned THREAD_SLOTS    = lstm_pkg::ThreadSlotsDef,
  parameter int unsigned PROBES_PER_SLOT = lstm_pkg::ProbesPerSlotDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     command_i,
  input  logic [lstm_pkg::SlotW-1:0]     thread_slot_i,
  input  logic [lstm_pkg::ProbeW-1:0]    probe_index_i,
  input  logic [lstm_pkg::SampleW-1:0]   runtime_i,
  output logic                           done_o,
  output logic                           report_valid_o,
  output logic [lstm_pkg::TotalW-1:0]    trimmed_total_o,
  output logic [lstm_pkg::SampleW-1:0]   trimmed_average_o,
  output logic [lstm_pkg::SampleW-1:0]   smallest_sample_o,
  output logic [lstm_pkg::SampleW-1:0]   largest_sample_o,
  output logic [lstm_pkg::CountW-1:0]    trimmed_calls_o
);

  localparam int unsigned Entries = THREAD_SLOTS * PROBES_PER_SLOT;
  localparam int unsigned AddrW   = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned SW      = lstm_pkg::SampleW;
  localparam int unsigned TW      = lstm_pkg::TotalW;
  localparam int unsigned CW      = lstm_pkg::CountW;
  localparam int unsigned DW      = lstm_pkg::DropW;

  function automatic lstm_pkg::entry_t apply_sample(lstm_pkg::entry_t e,
                                                    logic [SW-1:0] t);
    lstm_pkg::entry_t b;
    logic [TW:0]      sum;
    b = e;
    if (!e.valid) begin
      b.calls      = '0;
      b.total      = '0;
      b.max_first  = '0;
      b.max_second = '0;
      b.min_first  = '1;
      b.min_second = '1;
    end
    b.valid = 1'b1;
    if (b.calls != '1) begin
      b.calls = b.calls + 1'b1;
    end
    sum     = {1'b0, b.total} + (TW + 1)'(t);
    b.total = sum[TW] ? '1 : sum[TW-1:0];
    if (t > b.max_second) begin
      if (t > b.max_first) begin
        b.max_second = b.max_first;
        b.max_first  = t;
      end else begin
        b.max_second = t;
      end
    end
    if (t < b.min_second) begin
      if (t < b.min_first) begin
        b.min_second = b.min_first;
        b.min_first  = t;
      end else begin
        b.min_second = t;
      end
    end
    return b;
  endfunction

  lstm_pkg::state_e state_q, state_d;

  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic             ok_q, ok_d;
  logic [SW-1:0]    runtime_q, runtime_d;
  logic             elig_q, elig_d;
  logic [DW-1:0]    drop_q, drop_d;
  logic [TW-1:0]    src_q, src_d;
  logic [TW-1:0]    total_q, total_d;
  logic [CW-1:0]    calls_q, calls_d;
  logic [SW-1:0]    min_q, min_d;
  logic [SW-1:0]    max_q, max_d;
  logic [SW-1:0]    avg_q, avg_d;

  logic             accept;
  logic [31:0]      addr_full;
  logic [AddrW-1:0] in_addr;
  logic             in_ok;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  lstm_pkg::entry_t mem_wdata;
  lstm_pkg::entry_t mem_rdata;

  logic             div_start;
  logic             div_done;
  logic [TW-1:0]    div_quo;

  assign accept    = start && (state_q == lstm_pkg::ST_IDLE);
  assign addr_full = 32'(thread_slot_i) * 32'(PROBES_PER_SLOT) + 32'(probe_index_i);
  assign in_addr   = addr_full[AddrW-1:0];
  assign in_ok     = (32'(thread_slot_i) < 32'(THREAD_SLOTS)) &&
                     (32'(probe_index_i) < 32'(PROBES_PER_SLOT));

  lstm_mem #(
    .Depth (Entries),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (mem_rdata)
  );

  lstm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (total_d),
    .divisor_i  (calls_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lstm_pkg::ST_CLEAR: begin
        if (clr_cnt_q == AddrW'(Entries - 1)) begin
          state_d = lstm_pkg::ST_IDLE;
        end
      end
      lstm_pkg::ST_IDLE: begin
        if (start) begin
          unique case (command_i)
            lstm_pkg::CMD_RECORD: state_d = lstm_pkg::ST_UPDATE;
            lstm_pkg::CMD_REPORT: state_d = lstm_pkg::ST_REPORT;
            lstm_pkg::CMD_CLEAR:  state_d = lstm_pkg::ST_CLEAR;
            default:              state_d = lstm_pkg::ST_IDLE;
          endcase
        end
      end
      lstm_pkg::ST_UPDATE: state_d = lstm_pkg::ST_IDLE;
      lstm_pkg::ST_REPORT: state_d = elig_d ? lstm_pkg::ST_TRIM : lstm_pkg::ST_RESULT;
      lstm_pkg::ST_TRIM:   state_d = lstm_pkg::ST_DIVIDE;
      lstm_pkg::ST_DIVIDE: begin
        if (div_done) begin
          state_d = lstm_pkg::ST_RESULT;
        end
      end
      lstm_pkg::ST_RESULT: state_d = lstm_pkg::ST_IDLE;
      default:             state_d = lstm_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    clr_cnt_d = clr_cnt_q;
    addr_d    = addr_q;
    ok_d      = ok_q;
    runtime_d = runtime_q;
    elig_d    = elig_q;
    drop_d    = drop_q;
    src_d     = src_q;
    total_d   = total_q;
    calls_d   = calls_q;
    min_d     = min_q;
    max_d     = max_q;
    avg_d     = avg_q;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = apply_sample(mem_rdata, runtime_q);
    div_start = 1'b0;

    unique case (state_q)
      lstm_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
      lstm_pkg::ST_IDLE: begin
        clr_cnt_d = '0;
        if (start) begin
          addr_d    = in_addr;
          ok_d      = in_ok;
          runtime_d = runtime_i;
        end
      end
      lstm_pkg::ST_UPDATE: begin
        mem_we = ok_q;
      end
      lstm_pkg::ST_REPORT: begin
        elig_d  = ok_q && mem_rdata.valid && (mem_rdata.calls > CW'(lstm_pkg::TrimCount));
        drop_d  = DW'(mem_rdata.max_first) + DW'(mem_rdata.max_second) +
                  DW'(mem_rdata.min_first) + DW'(mem_rdata.min_second);
        src_d   = mem_rdata.total;
        calls_d = mem_rdata.calls - CW'(lstm_pkg::TrimCount);
        min_d   = mem_rdata.min_first;
        max_d   = mem_rdata.max_first;
      end
      lstm_pkg::ST_TRIM: begin
        // clamp at zero: a guard only, since the four dropped samples never exceed the total
        total_d   = (src_q > TW'(drop_q)) ? (src_q - TW'(drop_q)) : '0;
        div_start = 1'b1;
      end
      lstm_pkg::ST_DIVIDE: begin
        if (div_done) begin
          avg_d = (div_quo[TW-1:SW] != '0) ? '1 : div_quo[SW-1:0];
        end
      end
      lstm_pkg::ST_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lstm_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
      elig_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      elig_q    <= elig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    ok_q      <= ok_d;
    runtime_q <= runtime_d;
    drop_q    <= drop_d;
    src_q     <= src_d;
    total_q   <= total_d;
    calls_q   <= calls_d;
    min_q     <= min_d;
    max_q     <= max_d;
    avg_q     <= avg_d;
  end

  // Outputs
  always_comb begin
    busy              = (state_q != lstm_pkg::ST_IDLE);
    done_o            = (state_q == lstm_pkg::ST_RESULT);
    report_valid_o    = elig_q;
    trimmed_total_o   = elig_q ? total_q : '0;
    trimmed_average_o = elig_q ? avg_q   : '0;
    smallest_sample_o = elig_q ? min_q   : '0;
    largest_sample_o  = elig_q ? max_q   : '0;
    trimmed_calls_o   = elig_q ? calls_q : '0;
  end

endmodule

// ===== src/lstm_chk.sv =====
// Port-level checker for the latency statistics table, bound to the top level.
// Depends on lstm_pkg for the command codes.
module lstm_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic [1:0]                    command_i,
  input logic                          done_o,
  input logic                          report_valid_o,
  input logic [lstm_pkg::TotalW-1:0]   trimmed_total_o,
  input logic [lstm_pkg::SampleW-1:0]  trimmed_average_o,
  input logic [lstm_pkg::CountW-1:0]   trimmed_calls_o
);

  logic acc_real;

  assign acc_real = start && !busy &&
                    (command_i == lstm_pkg::CMD_RECORD ||
                     command_i == lstm_pkg::CMD_REPORT ||
                     command_i == lstm_pkg::CMD_CLEAR);

  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe outside a busy window");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_item_holds_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_real |=> busy && !done_o)
    else $error("accepted item did not hold busy");

  a_valid_calls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && report_valid_o) |-> (trimmed_calls_o != '0))
    else $error("valid report with zero trimmed calls");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !report_valid_o) |->
      (trimmed_total_o == '0 && trimmed_average_o == '0 && trimmed_calls_o == '0))
    else $error("invalid report carries nonzero fields");

endmodule

bind latency_stats_trimmed_mean lstm_chk u_lstm_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .command_i         (command_i),
  .done_o            (done_o),
  .report_valid_o    (report_valid_o),
  .trimmed_total_o   (trimmed_total_o),
  .trimmed_average_o (trimmed_average_o),
  .trimmed_calls_o   (trimmed_calls_o)
);

// ===== test/latency_stats_trimmed_mean_tb.sv =====
// Self-checking testbench for latency_stats_trimmed_mean: records, reports, clears.
// Depends on lstm_pkg and the top level; predicts every report and checks it
// field by field as it leaves the block.
module latency_stats_trimmed_mean_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned EntryCount  = lstm_pkg::ThreadSlotsDef * lstm_pkg::ProbesPerSlotDef;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int unsigned RandItems   = 728;
  localparam int unsigned CalmTail    = 100;
  localparam int unsigned DrainCycles = 2 * EntryCount;
  localparam int unsigned HotW        = lstm_pkg::SlotW + lstm_pkg::ProbeW;

  typedef struct packed {
    logic [1:0]                   op;
    logic [lstm_pkg::SlotW-1:0]   slot;
    logic [lstm_pkg::ProbeW-1:0]  probe;
    logic [lstm_pkg::SampleW-1:0] runtime;
    logic [3:0]                   gap;
  } stat_cmd_t;

  typedef struct packed {
    logic                         valid;
    logic [lstm_pkg::TotalW-1:0]  total;
    logic [lstm_pkg::SampleW-1:0] average;
    logic [lstm_pkg::SampleW-1:0] smallest;
    logic [lstm_pkg::SampleW-1:0] largest;
    logic [lstm_pkg::CountW-1:0]  calls;
  } report_t;

  logic                          clk_i;
  logic                          rst_ni            = 1'b0;
  logic                          start             = 1'b0;
  logic [1:0]                    command_i         = '0;
  logic [lstm_pkg::SlotW-1:0]    thread_slot_i     = '0;
  logic [lstm_pkg::ProbeW-1:0]   probe_index_i     = '0;
  logic [lstm_pkg::SampleW-1:0]  runtime_i         = '0;
  logic                          busy;
  logic                          done_o;
  logic                          report_valid_o;
  logic [lstm_pkg::TotalW-1:0]   trimmed_total_o;
  logic [lstm_pkg::SampleW-1:0]  trimmed_average_o;
  logic [lstm_pkg::SampleW-1:0]  smallest_sample_o;
  logic [lstm_pkg::SampleW-1:0]  largest_sample_o;
  logic [lstm_pkg::CountW-1:0]   trimmed_calls_o;

  stat_cmd_t          cmd_backlog[$];
  report_t            pending_reports[$];
  lstm_pkg::entry_t   stats_mem[EntryCount];
  stat_cmd_t          next_cmd;
  stat_cmd_t          live_cmd;
  bit                 staged     = 1'b0;
  int unsigned        hold_left  = 0;
  int unsigned        mismatches = 0;

  latency_stats_trimmed_mean DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .command_i        (command_i),
    .thread_slot_i    (thread_slot_i),
    .probe_index_i    (probe_index_i),
    .runtime_i        (runtime_i),
    .done_o           (done_o),
    .report_valid_o   (report_valid_o),
    .trimmed_total_o  (trimmed_total_o),
    .trimmed_average_o(trimmed_average_o),
    .smallest_sample_o(smallest_sample_o),
    .largest_sample_o (largest_sample_o),
    .trimmed_calls_o  (trimmed_calls_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic log_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic void push_cmd(logic [1:0] op, logic [lstm_pkg::SlotW-1:0] slot,
                                   logic [lstm_pkg::ProbeW-1:0] probe,
                                   logic [lstm_pkg::SampleW-1:0] rt,
                                   logic [3:0] gap);
    stat_cmd_t c;
    c.op      = op;
    c.slot    = slot;
    c.probe   = probe;
    c.runtime = rt;
    c.gap     = gap;
    cmd_backlog.push_back(c);
  endfunction

  // Add one runtime to an entry; an invalid entry restarts from cleared values.
  function automatic void fold_sample(int unsigned addr, logic [lstm_pkg::SampleW-1:0] t);
    lstm_pkg::entry_t              e;
    logic [lstm_pkg::TotalW:0]     sum;
    logic [lstm_pkg::SampleW-1:0]  held;
    e = stats_mem[addr];
    if (!e.valid) begin
      e            = '0;
      e.min_first  = '1;
      e.min_second = '1;
      e.valid      = 1'b1;
    end
    if (e.calls != '1) e.calls = e.calls + 1'b1;
    sum     = {1'b0, e.total} + (lstm_pkg::TotalW + 1)'(t);
    e.total = sum[lstm_pkg::TotalW] ? '1 : sum[lstm_pkg::TotalW-1:0];
    if (e.max_second < t) begin
      e.max_second = t;
      if (e.max_first < e.max_second) begin
        held         = e.max_first;
        e.max_first  = e.max_second;
        e.max_second = held;
      end
    end
    if (e.min_second > t) begin
      e.min_second = t;
      if (e.min_first > e.min_second) begin
        held         = e.min_first;
        e.min_first  = e.min_second;
        e.min_second = held;
      end
    end
    stats_mem[addr] = e;
  endfunction

  function automatic report_t trimmed_report(bit in_range, int unsigned addr);
    report_t          r;
    lstm_pkg::entry_t e;
    logic [63:0]      drop;
    logic [63:0]      rest;
    logic [63:0]      count;
    logic [63:0]      avg;
    r = '0;
    if (!in_range) return r;
    e = stats_mem[addr];
    if (!e.valid || e.calls <= lstm_pkg::TrimCount) return r;
    drop  = 64'(e.max_first) + 64'(e.max_second) + 64'(e.min_first) + 64'(e.min_second);
    rest  = (64'(e.total) > drop) ? 64'(e.total) - drop : 64'd0;
    count = 64'(e.calls) - 64'(lstm_pkg::TrimCount);
    avg   = rest / count;
    r.valid    = 1'b1;
    r.total    = rest[lstm_pkg::TotalW-1:0];
    r.average  = (avg > 64'hFFFF_FFFF) ? '1 : avg[lstm_pkg::SampleW-1:0];
    r.smallest = e.min_first;
    r.largest  = e.max_first;
    r.calls    = count[lstm_pkg::CountW-1:0];
    return r;
  endfunction

  function automatic void apply_cmd(stat_cmd_t c);
    bit          in_range;
    int unsigned addr;
    in_range = (c.slot < lstm_pkg::ThreadSlotsDef) && (c.probe < lstm_pkg::ProbesPerSlotDef);
    addr     = c.slot * lstm_pkg::ProbesPerSlotDef + c.probe;
    case (c.op)
      lstm_pkg::CMD_RECORD: if (in_range) fold_sample(addr, c.runtime);
      lstm_pkg::CMD_REPORT: pending_reports.push_back(trimmed_report(in_range, addr));
      lstm_pkg::CMD_CLEAR:  foreach (stats_mem[i]) stats_mem[i].valid = 1'b0;
      default: ;
    endcase
  endfunction

  // Present one item at a time; predict it at the edge that accepts it.
  always @(posedge clk_i) begin : item_driver
    if (rst_ni) begin
      if (start && !busy) apply_cmd(live_cmd);
      if (!start || !busy) begin
        if (!staged && cmd_backlog.size() != 0) begin
          next_cmd  = cmd_backlog.pop_front();
          staged    = 1'b1;
          hold_left = 32'(next_cmd.gap);
        end
        if (staged && hold_left == 0) begin
          live_cmd      = next_cmd;
          staged        = 1'b0;
          start         <= 1'b1;
          command_i     <= next_cmd.op;
          thread_slot_i <= next_cmd.slot;
          probe_index_i <= next_cmd.probe;
          runtime_i     <= next_cmd.runtime;
        end else begin
          if (hold_left != 0) hold_left--;
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : report_monitor
    report_t want;
    if (rst_ni && done_o) begin
      if (pending_reports.size() == 0) begin
        log_mismatch("unexpected report", 64'(trimmed_total_o), 64'd0);
      end else begin
        want = pending_reports.pop_front();
        if (report_valid_o !== want.valid)
          log_mismatch("report_valid", 64'(report_valid_o), 64'(want.valid));
        if (trimmed_total_o !== want.total)
          log_mismatch("trimmed_total", 64'(trimmed_total_o), 64'(want.total));
        if (trimmed_average_o !== want.average)
          log_mismatch("trimmed_average", 64'(trimmed_average_o), 64'(want.average));
        if (smallest_sample_o !== want.smallest)
          log_mismatch("smallest_sample", 64'(smallest_sample_o), 64'(want.smallest));
        if (largest_sample_o !== want.largest)
          log_mismatch("largest_sample", 64'(largest_sample_o), 64'(want.largest));
        if (trimmed_calls_o !== want.calls)
          log_mismatch("trimmed_calls", 64'(trimmed_calls_o), 64'(want.calls));
      end
    end
  end

  initial begin
    logic [HotW-1:0]               hot [6];
    logic [lstm_pkg::SlotW-1:0]    slot;
    logic [lstm_pkg::ProbeW-1:0]   probe;
    logic [lstm_pkg::SampleW-1:0]  rt;
    logic [lstm_pkg::SampleW-1:0]  last_rt;
    logic [1:0]                    op;
    logic [3:0]                    gap;
    int unsigned                   pick;
    bit                            calm;

    foreach (stats_mem[i]) stats_mem[i] = '0;

    // Directed: never-written entry, ties and extremes, the four-call boundary,
    // the unused code, and reports across a clear.
    push_cmd(lstm_pkg::CMD_REPORT, 3'd0, 6'd0, '0, 4'd0);
    push_cmd(lstm_pkg::CMD_RECORD, 3'd7, 6'd63, 32'hFFFF_FFFF, 4'd0);
    push_cmd(lstm_pkg::CMD_RECORD, 3'd7, 6'd63, 32'd0, 4'd0);
    push_cmd(lstm_pkg::CMD_RECORD, 3'd7, 6'd63, 32'd5, 4'd0);
    push_cmd(lstm_pkg::CMD_RECORD, 3'd7, 6'd63, 32'd5, 4'd0);
    push_cmd(lstm_pkg::CMD_RECORD, 3'd7, 6'd63, 32'hFFFF_FFFF, 4'd0);
    push_cmd(lstm_pkg::CMD_RECORD, 3'd7, 6'd63, 32'd100, 4'd0);
    push_cmd(lstm_pkg::CMD_REPORT, 3'd7, 6'd63, '0, 4'd0);
    repeat (4) push_cmd(lstm_pkg::CMD_RECORD, 3'd0, 6'd0, 32'd3, 4'd0);
    push_cmd(lstm_pkg::CMD_REPORT, 3'd0, 6'd0, '0, 4'd0);
    push_cmd(lstm_pkg::CMD_RECORD, 3'd0, 6'd0, 32'd3, 4'd0);
    push_cmd(lstm_pkg::CMD_REPORT, 3'd0, 6'd0, '0, 4'd0);
    push_cmd(CMD_UNUSED, 3'd2, 6'd5, 32'd123, 4'd0);
    push_cmd(lstm_pkg::CMD_CLEAR, 3'd0, 6'd0, '0, 4'd0);
    push_cmd(lstm_pkg::CMD_REPORT, 3'd7, 6'd63, '0, 4'd0);
    push_cmd(lstm_pkg::CMD_RECORD, 3'd7, 6'd63, 32'd42, 4'd0);
    push_cmd(lstm_pkg::CMD_RECORD, 3'd7, 6'd63, 32'd7, 4'd0);
    push_cmd(lstm_pkg::CMD_RECORD, 3'd7, 6'd63, 32'd8, 4'd0);
    push_cmd(lstm_pkg::CMD_RECORD, 3'd7, 6'd63, 32'd9, 4'd0);
    push_cmd(lstm_pkg::CMD_RECORD, 3'd7, 6'd63, 32'd10, 4'd0);
    push_cmd(lstm_pkg::CMD_REPORT, 3'd7, 6'd63, '0, 4'd0);

    // Random: most traffic hits a few hot entries so reports see full statistics.
    foreach (hot[i]) hot[i] = HotW'($urandom);
    last_rt = '0;
    calm    = 1'b0;
    for (int n = 0; n < RandItems; n++) begin
      if (n % 40 == 0) calm = ($urandom_range(0, 2) == 0);
      if (n >= RandItems - CalmTail) calm = 1'b1;
      gap  = (!calm && $urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 15)) : 4'd0;
      pick = $urandom_range(0, 99);
      if (pick < 68)      op = lstm_pkg::CMD_RECORD;
      else if (pick < 94) op = lstm_pkg::CMD_REPORT;
      else if (pick < 98) op = CMD_UNUSED;
      else                op = lstm_pkg::CMD_CLEAR;
      if ($urandom_range(0, 4) == 0) begin
        {slot, probe} = HotW'($urandom);
      end else begin
        {slot, probe} = hot[$urandom_range(0, 5)];
      end
      case ($urandom_range(0, 6))
        0:       rt = $urandom_range(0, 1000);
        1:       rt = $urandom;
        2:       rt = '0;
        3:       rt = '1;
        4:       rt = last_rt;
        5:       rt = $urandom_range(32'hFFFF_0000, 32'hFFFF_FFFF);
        default: rt = $urandom_range(0, 100_000);
      endcase
      last_rt = rt;
      push_cmd(op, slot, probe, rt, gap);
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog.size() != 0 || staged || start) @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("latency_stats_trimmed_mean verification clean");
    end else begin
      $display("latency_stats_trimmed_mean verification failed");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("latency_stats_trimmed_mean verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/lstm_pkg.sv
src/lstm_mem.sv
src/lstm_div.sv
src/latency_stats_trimmed_mean.sv
src/lstm_chk.sv
test/latency_stats_trimmed_mean_tb.sv
